### rtl/tiq_pkg.sv
package tiq_pkg;

    localparam int GROUPS = 3;

    localparam logic [2:0] CMD_ADD   = 3'd0;
    localparam logic [2:0] CMD_MUL   = 3'd1;
    localparam logic [2:0] CMD_LOAD  = 3'd2;
    localparam logic [2:0] CMD_STORE = 3'd3;
    localparam logic [2:0] CMD_DRAIN = 3'd4;

    localparam logic [1:0] CFG_ADD_LAT  = 2'd0;
    localparam logic [1:0] CFG_MUL_LAT  = 2'd1;
    localparam logic [1:0] CFG_LOAD_LAT = 2'd2;

    localparam logic [3:0] RESET_ADD_LAT  = 4'd3;
    localparam logic [3:0] RESET_MUL_LAT  = 4'd4;
    localparam logic [3:0] RESET_LOAD_LAT = 4'd3;

    typedef struct packed {
        logic [2:0] command;
        logic [2:0] dest_reg;
        logic [2:0] src1_reg;
        logic [2:0] src2_reg;
    } t_cmd;

    typedef struct packed {
        logic [31:0] cycles_elapsed;
        logic [31:0] full_stall_count;
        logic [31:0] bus_stall_count;
        logic        all_idle;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_TICK,
        ST_PUSH,
        ST_READ,
        ST_BCAST,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        RET_ISSUE,
        RET_DRAIN,
        RET_DONE
    } t_ret;

endpackage

### rtl/tiq_front.sv
module tiq_front
    import tiq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_ready
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

endmodule

### rtl/tiq_engine.sv
module tiq_engine
    import tiq_pkg::*;
#(
    parameter int STATIONS_PER_GROUP = 8,
    parameter int ARCH_REGS          = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic [1:0] i_cfg_index,
    input  logic [3:0] i_cfg_data,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_ready,
    output logic       o_res_valid,
    output t_result    o_res,
    input  logic       i_res_ready
);

    localparam int NST = GROUPS * STATIONS_PER_GROUP;
    localparam int TW  = $clog2(NST + 1);
    localparam int PW  = $clog2(NST);
    localparam int FW  = $clog2(NST + 1);
    localparam int RW  = $clog2(ARCH_REGS);

    logic [3:0]    r_add_lat;
    logic [3:0]    r_mul_lat;
    logic [3:0]    r_load_lat;
    logic [NST-1:0] r_occ;
    logic [3:0]    r_cd [NST];
    logic [TW-1:0] r_w1 [NST];
    logic [TW-1:0] r_w2 [NST];
    logic [ARCH_REGS-1:0] r_pend;
    logic [TW-1:0] r_prod [ARCH_REGS];
    logic [TW-1:0] r_fq [NST];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [FW-1:0] r_fill;
    logic [NST-1:0] r_mask;
    logic [TW-1:0] r_head;
    logic [31:0]   r_cycles;
    logic [31:0]   r_full;
    logic [31:0]   r_bus;
    t_state        r_state;
    t_state        n_state;
    t_ret          r_ret;
    t_ret          n_ret;
    t_cmd          r_cmd;

    logic [1:0]    grp;
    logic          free_found;
    logic [TW-1:0] free_tag;
    logic [3:0]    lat;
    logic          s1_in;
    logic          s2_in;
    logic [RW-1:0] s1_i;
    logic [RW-1:0] s2_i;
    logic [TW-1:0] w1_new;
    logic [TW-1:0] w2_new;
    logic [NST-1:0] elig;
    logic [NST-1:0] fin;
    logic [TW-1:0] push_tag;
    logic [NST-1:0] push_bit;
    logic [FW-1:0] fill_dec;
    logic [32:0]   bus_sum;
    logic [TW-1:0] head_p1;

    assign grp = r_cmd.command[1:0];

    always_comb begin
        free_found = 1'b0;
        free_tag   = '0;
        for (int g = 0; g < GROUPS; g++) begin
            for (int i = 0; i < STATIONS_PER_GROUP; i++) begin
                if (!free_found && (32'(g) == 32'(grp))
                        && !r_occ[g * STATIONS_PER_GROUP + i]) begin
                    free_found = 1'b1;
                    free_tag   = TW'(g * STATIONS_PER_GROUP + i);
                end
            end
        end
    end

    always_comb begin
        case (r_cmd.command)
            CMD_ADD: lat = r_add_lat;
            CMD_MUL: lat = r_mul_lat;
            default: lat = r_load_lat;
        endcase
        if (lat == 4'd0) begin
            lat = 4'd1;
        end
    end

    assign s1_in  = (32'(r_cmd.src1_reg) < 32'(ARCH_REGS));
    assign s2_in  = (32'(r_cmd.src2_reg) < 32'(ARCH_REGS));
    assign s1_i   = RW'(r_cmd.src1_reg);
    assign s2_i   = RW'(r_cmd.src2_reg);
    assign w1_new = (s1_in && r_pend[s1_i]) ? r_prod[s1_i] + TW'(1) : '0;
    assign w2_new = (s2_in && r_pend[s2_i]) ? r_prod[s2_i] + TW'(1) : '0;

    always_comb begin
        for (int s = 0; s < NST; s++) begin
            elig[s] = r_occ[s] && (r_cd[s] != 4'd0) && (r_w1[s] == '0)
                      && (r_w2[s] == '0);
            fin[s]  = elig[s] && (r_cd[s] == 4'd1);
        end
    end

    always_comb begin
        push_tag = '0;
        push_bit = '0;
        for (int s = NST - 1; s >= 0; s--) begin
            if (r_mask[s]) begin
                push_tag = TW'(s);
                push_bit = '0;
                push_bit[s] = 1'b1;
            end
        end
    end

    assign fill_dec = r_fill - FW'(1);
    assign bus_sum  = {1'b0, r_bus} + 33'(fill_dec);
    assign head_p1  = r_head + TW'(1);

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        o_cmd_ready = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    case (i_cmd.command)
                        CMD_ADD, CMD_MUL, CMD_LOAD: n_state = ST_ISSUE;
                        CMD_DRAIN: n_state = ST_DRAIN;
                        default: begin
                            n_state = ST_TICK;
                            n_ret   = RET_DONE;
                        end
                    endcase
                end
            end
            ST_ISSUE: begin
                n_state = ST_TICK;
                n_ret   = free_found ? RET_DONE : RET_ISSUE;
            end
            ST_DRAIN: begin
                if (|r_pend) begin
                    n_state = ST_TICK;
                    n_ret   = RET_DRAIN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_TICK: n_state = ST_PUSH;
            ST_PUSH: begin
                if (r_mask == '0) begin
                    n_state = ST_READ;
                end
            end
            ST_READ, ST_BCAST: begin
                if (r_state == ST_READ && r_fill != '0) begin
                    n_state = ST_BCAST;
                end else begin
                    case (r_ret)
                        RET_ISSUE: n_state = ST_ISSUE;
                        RET_DRAIN: n_state = ST_DRAIN;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= RET_DONE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add_lat  <= RESET_ADD_LAT;
            r_mul_lat  <= RESET_MUL_LAT;
            r_load_lat <= RESET_LOAD_LAT;
            r_occ      <= '0;
            r_pend     <= '0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fill     <= '0;
            r_mask     <= '0;
            r_cycles   <= '0;
            r_full     <= '0;
            r_bus      <= '0;
            for (int s = 0; s < NST; s++) begin
                r_cd[s] <= '0;
                r_w1[s] <= '0;
                r_w2[s] <= '0;
            end
            for (int r = 0; r < ARCH_REGS; r++) begin
                r_prod[r] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ADD_LAT:  r_add_lat  <= i_cfg_data;
                    CFG_MUL_LAT:  r_mul_lat  <= i_cfg_data;
                    CFG_LOAD_LAT: r_load_lat <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                ST_ISSUE: begin
                    if (free_found) begin
                        for (int s = 0; s < NST; s++) begin
                            if (TW'(s) == free_tag) begin
                                r_occ[s] <= 1'b1;
                                r_cd[s]  <= lat;
                                r_w1[s]  <= (r_cmd.command == CMD_LOAD) ? '0 : w1_new;
                                r_w2[s]  <= (r_cmd.command == CMD_LOAD) ? '0 : w2_new;
                            end
                        end
                        for (int r = 0; r < ARCH_REGS; r++) begin
                            if (32'(r) == 32'(r_cmd.dest_reg)) begin
                                r_pend[r] <= 1'b1;
                                r_prod[r] <= free_tag;
                            end
                        end
                    end else if (r_full != '1) begin
                        r_full <= r_full + 32'd1;
                    end
                end
                ST_TICK: begin
                    if (r_cycles != '1) begin
                        r_cycles <= r_cycles + 32'd1;
                    end
                    for (int s = 0; s < NST; s++) begin
                        if (elig[s]) begin
                            r_cd[s] <= r_cd[s] - 4'd1;
                        end
                    end
                    r_mask <= fin;
                end
                ST_PUSH: begin
                    if (r_mask != '0) begin
                        r_mask   <= r_mask & ~push_bit;
                        r_wr_ptr <= (r_wr_ptr == PW'(NST - 1)) ? '0 : r_wr_ptr + PW'(1);
                        r_fill   <= r_fill + FW'(1);
                    end
                end
                ST_BCAST: begin
                    for (int r = 0; r < ARCH_REGS; r++) begin
                        if (r_pend[r] && r_prod[r] == r_head) begin
                            r_pend[r] <= 1'b0;
                            r_prod[r] <= '0;
                        end
                    end
                    for (int s = 0; s < NST; s++) begin
                        if (TW'(s) == r_head) begin
                            r_occ[s] <= 1'b0;
                            r_cd[s]  <= '0;
                            r_w1[s]  <= '0;
                            r_w2[s]  <= '0;
                        end else begin
                            if (r_w1[s] == head_p1) begin
                                r_w1[s] <= '0;
                            end
                            if (r_w2[s] == head_p1) begin
                                r_w2[s] <= '0;
                            end
                        end
                    end
                    r_rd_ptr <= (r_rd_ptr == PW'(NST - 1)) ? '0 : r_rd_ptr + PW'(1);
                    r_fill   <= fill_dec;
                    r_bus    <= bus_sum[32] ? '1 : bus_sum[31:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_cmd_valid) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PUSH && r_mask != '0) begin
            r_fq[r_wr_ptr] <= push_tag;
        end
        r_head <= r_fq[r_rd_ptr];
    end

    assign o_res.cycles_elapsed   = r_cycles;
    assign o_res.full_stall_count = r_full;
    assign o_res.bus_stall_count  = r_bus;
    assign o_res.all_idle         = ~|r_pend;

endmodule

### rtl/tomasulo_issue_timing_model.sv
// Each simulated cycle runs a tick, a push step per station finishing in it, a closing
// push and a queue read, plus a broadcast when a finished tag waits; full-group stalls
// and drains add such cycles. Each item leaves the front queue, makes its issue attempts
// or drain checks, presents its result and passes the output register, one at a time.
// The front queue holds two transfers so the sender can run ahead of the back end.
// Synchronous active-low reset clears all stations, registers, queue and counters.
module tomasulo_issue_timing_model
    import tiq_pkg::*;
#(
    parameter int STATIONS_PER_GROUP = 8,
    parameter int ARCH_REGS          = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic [2:0]  i_dest_reg,
    input  logic [2:0]  i_src1_reg,
    input  logic [2:0]  i_src2_reg,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_cycles_elapsed,
    output logic [31:0] o_full_stall_count,
    output logic [31:0] o_bus_stall_count,
    output logic        o_all_idle,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    t_cmd    in_cmd;
    t_cmd    q_cmd;
    logic    q_valid;
    logic    q_ready;
    logic    res_valid;
    logic    res_ready;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    assign in_cmd.command  = i_command;
    assign in_cmd.dest_reg = i_dest_reg;
    assign in_cmd.src1_reg = i_src1_reg;
    assign in_cmd.src2_reg = i_src2_reg;

    tiq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (in_cmd),
        .o_cmd_valid (q_valid),
        .o_cmd       (q_cmd),
        .i_cmd_ready (q_ready)
    );

    tiq_engine #(
        .STATIONS_PER_GROUP (STATIONS_PER_GROUP),
        .ARCH_REGS          (ARCH_REGS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_ready (q_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    assign res_ready   = !r_out_valid || i_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_cycles_elapsed   = r_out.cycles_elapsed;
    assign o_full_stall_count = r_out.full_stall_count;
    assign o_bus_stall_count  = r_out.bus_stall_count;
    assign o_all_idle         = r_out.all_idle;

endmodule

### rtl/tiq_checker.sv
module tiq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_cycles_elapsed,
    input logic [31:0] o_full_stall_count,
    input logic [31:0] o_bus_stall_count,
    input logic        o_all_idle
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Result valid after reset.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cycles_elapsed))
        else $error("Stalled result changed.");

    a_full_le_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_full_stall_count <= o_cycles_elapsed)
        else $error("Full stalls exceed cycles.");

    a_zero_cycles_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cycles_elapsed == 32'd0 |-> o_all_idle
            && o_bus_stall_count == 32'd0)
        else $error("Work recorded without any cycle.");

endmodule

bind tomasulo_issue_timing_model tiq_checker u_tiq_checker (.*);

### bench/tb_tomasulo_issue_timing_model.sv
`timescale 1ns / 100ps

module tb_tomasulo_issue_timing_model;
    import tiq_pkg::*;

    localparam int NSTN = 24;
    localparam int NREG = 8;
    localparam int STALL_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_command = '0;
    logic [2:0]  i_dest_reg = '0;
    logic [2:0]  i_src1_reg = '0;
    logic [2:0]  i_src2_reg = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_cycles_elapsed;
    logic [31:0] o_full_stall_count;
    logic [31:0] o_bus_stall_count;
    logic        o_all_idle;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [3:0]  i_cfg_data = '0;

    tomasulo_issue_timing_model u_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Scheduler state as the bench tracks it.
    logic        stn_busy [NSTN];
    logic [5:0]  stn_wait_a [NSTN];
    logic [5:0]  stn_wait_b [NSTN];
    logic [3:0]  stn_count [NSTN];
    logic        reg_busy [NREG];
    logic [4:0]  reg_tag [NREG];
    logic [4:0]  done_tags [$];
    logic [3:0]  unit_lat [GROUPS];
    logic [31:0] sim_cycles, full_stalls, bus_stalls;

    t_cmd    cmd_queue [$];
    t_result expected_results [$];
    int      errors = 0;

    function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + b;
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic bit any_reg_busy();
        foreach (reg_busy[r]) if (reg_busy[r]) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void retire_tag(logic [4:0] tag);
        foreach (reg_busy[r]) begin
            if (reg_busy[r] && reg_tag[r] == tag) begin
                reg_busy[r] = 1'b0;
                reg_tag[r] = '0;
            end
        end
        for (int s = 0; s < NSTN; s++) begin
            if (stn_wait_a[s] == tag + 6'd1) stn_wait_a[s] = '0;
            if (stn_wait_b[s] == tag + 6'd1) stn_wait_b[s] = '0;
        end
        if (tag < NSTN) begin
            stn_busy[tag] = 1'b0;
            stn_count[tag] = '0;
            stn_wait_a[tag] = '0;
            stn_wait_b[tag] = '0;
        end
    endfunction

    function automatic void advance_cycle();
        logic [4:0] tag;
        sim_cycles = sat_sum(sim_cycles, 1);
        for (int s = 0; s < NSTN; s++) begin
            if (stn_busy[s] && stn_count[s] != 0 && stn_wait_a[s] == 0 && stn_wait_b[s] == 0) begin
                stn_count[s]--;
                if (stn_count[s] == 0 && done_tags.size() < NSTN) done_tags.push_back(5'(s));
            end
        end
        if (done_tags.size() > 0) begin
            tag = done_tags.pop_front();
            retire_tag(tag);
            bus_stalls = sat_sum(bus_stalls, done_tags.size());
        end
    endfunction

    function automatic int first_free(int grp);
        for (int i = 0; i < 8; i++) if (!stn_busy[grp * 8 + i]) return grp * 8 + i;
        return -1;
    endfunction

    function automatic logic [5:0] source_wait(logic [2:0] r);
        return reg_busy[r] ? {1'b0, reg_tag[r]} + 6'd1 : 6'd0;
    endfunction

    function automatic void dispatch(int grp, t_cmd c);
        int st, guard;
        logic [3:0] lat;
        guard = 0;
        st = first_free(grp);
        while (st < 0 && guard < 65536) begin
            full_stalls = sat_sum(full_stalls, 1);
            advance_cycle();
            st = first_free(grp);
            guard++;
        end
        if (st < 0) return;
        lat = (unit_lat[grp] == 0) ? 4'd1 : unit_lat[grp];
        stn_busy[st] = 1'b1;
        stn_count[st] = lat;
        if (grp == 2) begin
            stn_wait_a[st] = '0;
            stn_wait_b[st] = '0;
        end else begin
            stn_wait_a[st] = source_wait(c.src1_reg);
            stn_wait_b[st] = source_wait(c.src2_reg);
        end
        reg_busy[c.dest_reg] = 1'b1;
        reg_tag[c.dest_reg] = 5'(st);
    endfunction

    function automatic t_result schedule_cmd(t_cmd c);
        t_result r;
        int guard;
        if (c.command == CMD_ADD || c.command == CMD_MUL || c.command == CMD_LOAD) begin
            dispatch(int'(c.command), c);
            advance_cycle();
        end else if (c.command == CMD_DRAIN) begin
            guard = 0;
            while (any_reg_busy() && guard < 65536) begin
                advance_cycle();
                guard++;
            end
        end else begin
            advance_cycle();
        end
        r.cycles_elapsed = sim_cycles;
        r.full_stall_count = full_stalls;
        r.bus_stall_count = bus_stalls;
        r.all_idle = !any_reg_busy();
        return r;
    endfunction

    // Sender: bursts of transfers separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                expected_results.push_back(
                    schedule_cmd({i_command, i_dest_reg, i_src1_reg, i_src2_reg}));
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (cmd_queue.size() > 0) begin
                    t_cmd c;
                    c = cmd_queue.pop_front();
                    i_command <= c.command;
                    i_dest_reg <= c.dest_reg;
                    i_src1_reg <= c.src1_reg;
                    i_src2_reg <= c.src2_reg;
                    i_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern changes mode every so often.
    int rx_mode = 0;
    int rx_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transfer");
                    errors++;
                end else begin
                    t_result e;
                    e = expected_results.pop_front();
                    if (o_cycles_elapsed !== e.cycles_elapsed) begin
                        $error("cycles_elapsed exp %0d got %0d", e.cycles_elapsed, o_cycles_elapsed);
                        errors++;
                    end
                    if (o_full_stall_count !== e.full_stall_count) begin
                        $error("full_stall_count exp %0d got %0d", e.full_stall_count,
                               o_full_stall_count);
                        errors++;
                    end
                    if (o_bus_stall_count !== e.bus_stall_count) begin
                        $error("bus_stall_count exp %0d got %0d", e.bus_stall_count,
                               o_bus_stall_count);
                        errors++;
                    end
                    if (o_all_idle !== e.all_idle) begin
                        $error("all_idle exp %0d got %0d", e.all_idle, o_all_idle);
                        errors++;
                    end
                end
            end
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(5, 60);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= 1'($urandom_range(0, 1));
                default: i_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)
                || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ADD_LAT:  unit_lat[0] = val;
            CFG_MUL_LAT:  unit_lat[1] = val;
            CFG_LOAD_LAT: unit_lat[2] = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (cmd_queue.size() != 0 || i_valid || expected_results.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_cmd mk(logic [2:0] op, logic [2:0] d, logic [2:0] a, logic [2:0] b);
        t_cmd c;
        c.command = op;
        c.dest_reg = d;
        c.src1_reg = a;
        c.src2_reg = b;
        return c;
    endfunction

    task automatic add_random(int n);
        t_cmd c;
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            c = mk(3'($urandom_range(0, 2)), 3'($urandom_range(0, 7)),
                   3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            if (pick < 4) c.command = CMD_DRAIN;
            else if (pick < 10) c.command = 3'($urandom_range(5, 7));
            else if (pick < 13) c.command = CMD_STORE;
            cmd_queue.push_back(c);
        end
    endtask

    initial begin
        foreach (stn_busy[s]) begin
            stn_busy[s] = 1'b0;
            stn_wait_a[s] = '0;
            stn_wait_b[s] = '0;
            stn_count[s] = '0;
        end
        foreach (reg_busy[r]) begin
            reg_busy[r] = 1'b0;
            reg_tag[r] = '0;
        end
        unit_lat[0] = RESET_ADD_LAT;
        unit_lat[1] = RESET_MUL_LAT;
        unit_lat[2] = RESET_LOAD_LAT;
        sim_cycles = '0;
        full_stalls = '0;
        bus_stalls = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Dependencies, every command, odd codes, then a full add group.
        cmd_queue.push_back(mk(CMD_ADD, 3'd1, 3'd0, 3'd0));
        cmd_queue.push_back(mk(CMD_MUL, 3'd2, 3'd1, 3'd1));
        cmd_queue.push_back(mk(CMD_LOAD, 3'd3, 3'd2, 3'd2));
        cmd_queue.push_back(mk(CMD_ADD, 3'd7, 3'd7, 3'd3));
        cmd_queue.push_back(mk(CMD_STORE, 3'd0, 3'd7, 3'd7));
        cmd_queue.push_back(mk(3'd5, 3'd7, 3'd0, 3'd7));
        cmd_queue.push_back(mk(3'd6, 3'd0, 3'd7, 3'd0));
        cmd_queue.push_back(mk(3'd7, 3'd7, 3'd7, 3'd7));
        cmd_queue.push_back(mk(CMD_DRAIN, 3'd0, 3'd0, 3'd0));
        cmd_queue.push_back(mk(CMD_DRAIN, 3'd7, 3'd7, 3'd7));
        for (int k = 0; k < 10; k++) cmd_queue.push_back(mk(CMD_ADD, 3'(k), 3'(k + 1), 3'(k)));
        for (int k = 0; k < 3; k++) cmd_queue.push_back(mk(CMD_MUL, 3'(k), 3'(k), 3'(7 - k)));
        cmd_queue.push_back(mk(CMD_DRAIN, 3'd0, 3'd0, 3'd0));
        add_random(350);
        wait_idle();

        write_reg(CFG_ADD_LAT, 4'd15);
        write_reg(CFG_MUL_LAT, 4'd15);
        write_reg(CFG_LOAD_LAT, 4'd15);
        add_random(350);
        wait_idle();

        write_reg(CFG_ADD_LAT, 4'd1);
        write_reg(CFG_MUL_LAT, 4'd1);
        write_reg(CFG_LOAD_LAT, 4'd1);
        add_random(350);
        wait_idle();

        // A latency setting of zero is treated as the smallest nonzero setting; index three writes nothing.
        write_reg(CFG_ADD_LAT, 4'd0);
        write_reg(CFG_MUL_LAT, 4'd0);
        write_reg(CFG_LOAD_LAT, 4'd0);
        write_reg(2'd3, 4'd15);
        add_random(350);
        wait_idle();

        for (int p = 0; p < 3; p++) begin
            write_reg(CFG_ADD_LAT, 4'($urandom_range(0, 15)));
            write_reg(CFG_MUL_LAT, 4'($urandom_range(0, 15)));
            write_reg(CFG_LOAD_LAT, 4'($urandom_range(0, 15)));
            add_random(170);
            wait_idle();
        end

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
